@@ rtl/tle_pkg.sv @@
package tle_pkg;

  // Bytes with a meaning of their own on the keyboard or the display.
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_EOT    = 8'h04;
  localparam logic [7:0] KEY_WERASE = 8'h17;
  localparam logic [7:0] KEY_KILL   = 8'h15;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_SPACE  = 8'h20;
  localparam logic [7:0] KEY_TILDE  = 8'h7E;
  localparam logic [7:0] KEY_BELL   = 8'h07;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_NUL    = 8'h00;

  // Class of the latched key byte.
  typedef logic [2:0] kclass_t;
  localparam kclass_t KC_CR     = 3'd0;
  localparam kclass_t KC_EOT    = 3'd1;
  localparam kclass_t KC_WERASE = 3'd2;
  localparam kclass_t KC_KILL   = 3'd3;
  localparam kclass_t KC_BS     = 3'd4;
  localparam kclass_t KC_PRINT  = 3'd5;
  localparam kclass_t KC_OTHER  = 3'd6;

  // Source of the byte loaded into the output register.
  typedef logic [2:0] bsel_t;
  localparam bsel_t BSEL_LF   = 3'd0;
  localparam bsel_t BSEL_NUL  = 3'd1;
  localparam bsel_t BSEL_CR   = 3'd2;
  localparam bsel_t BSEL_BS   = 3'd3;
  localparam bsel_t BSEL_SP   = 3'd4;
  localparam bsel_t BSEL_BELL = 3'd5;
  localparam bsel_t BSEL_KEY  = 3'd6;
  localparam bsel_t BSEL_RAM  = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  key_ld;
    logic  out_ld;
    bsel_t byte_sel;
    logic  out_last;
    logic  out_end;
    logic  clr_counts;
    logic  set_fin;
    logic  store_key;
    logic  bs_dec;
    logic  pos_init;
    logic  pos_dec;
    logic  wr_space;
    logic  rd_pos;
    logic  line_from_pos;
    logic  j_clr;
    logic  rd_j;
    logic  j_inc;
  } tle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kclass_t kclass;
    logic    finished;
    logic    line_zero;
    logic    room;
    logic    pos_zero;
    logic    rd_space;
    logic    shown_zero;
    logic    j_last;
    logic    out_free;
  } tle_stat_t;

endpackage

@@ rtl/terminal_line_editor.sv @@
// The key byte is latched, classified in the dispatch state and its first echo byte is
// then loaded into the output register once that is free, except for a word erase,
// which walks back through the line store before its carriage return. A new key is
// taken only in the idle state, after the last byte of its run has been loaded; a word
// erase reads each byte walked back and each redrawn byte through the single read port.
// Reset (rst_n, synchronous, active low) clears the counts, the session flag and the
// output; the limit returns to 40 and the line store keeps its contents.
module terminal_line_editor import tle_pkg::*; #(
  parameter int LINE_MAX = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_key_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_line_limit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_echo_byte,
  output logic       out_run_last,
  output logic       out_session_end
);

  tle_cmd_t  cmd;
  tle_stat_t stat;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  tle_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tle_datapath #(
    .LINE_MAX(LINE_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_key_byte    (in_key_byte),
    .cfg_valid      (cfg_valid),
    .cfg_line_limit (cfg_line_limit),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_echo_byte  (out_echo_byte),
    .out_run_last   (out_run_last),
    .out_session_end(out_session_end),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

@@ rtl/tle_ram.sv @@
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tle_datapath.sv @@
module tle_datapath import tle_pkg::*; #(
  parameter int LINE_MAX = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_key_byte,
  input  logic       cfg_valid,
  input  logic [5:0] cfg_line_limit,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_echo_byte,
  output logic       out_run_last,
  output logic       out_session_end,
  input  tle_cmd_t   cmd,
  output tle_stat_t  stat
);

  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [5:0] LMAX = 6'(LINE_MAX);

  logic [7:0]    key_r;
  logic [5:0]    line_limit_r;
  logic [5:0]    line_count_r, line_count_nxt;
  logic [5:0]    shown_count_r, shown_count_nxt;
  logic          finished_r;
  logic [5:0]    pos_r;
  logic [5:0]    pos_m1;
  logic [5:0]    j_r;
  logic [5:0]    j_p1;
  logic [5:0]    eff_limit;
  logic          out_valid_r;
  logic [7:0]    echo_r;
  logic          last_r;
  logic          end_r;
  logic [7:0]    out_byte;
  logic [7:0]    ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  kclass_t       kclass;

  assign pos_m1    = pos_r - 6'd1;
  assign j_p1      = j_r + 6'd1;
  assign eff_limit = (line_limit_r < LMAX) ? line_limit_r : LMAX;

  // Key classification.
  always_comb begin
    if (key_r == KEY_CR) begin
      kclass = KC_CR;
    end else if (key_r == KEY_EOT) begin
      kclass = KC_EOT;
    end else if (key_r == KEY_WERASE) begin
      kclass = KC_WERASE;
    end else if (key_r == KEY_KILL) begin
      kclass = KC_KILL;
    end else if (key_r == KEY_BS) begin
      kclass = KC_BS;
    end else if (key_r >= KEY_SPACE && key_r <= KEY_TILDE) begin
      kclass = KC_PRINT;
    end else begin
      kclass = KC_OTHER;
    end
  end

  // Line store: printable bytes go in at the line end, word erase writes spaces.
  assign ram_we    = cmd.store_key | cmd.wr_space;
  assign ram_waddr = cmd.store_key ? line_count_r[AW-1:0] : pos_m1[AW-1:0];
  assign ram_wdata = cmd.store_key ? key_r : KEY_SPACE;
  assign ram_raddr = cmd.rd_j ? j_r[AW-1:0] : pos_m1[AW-1:0];

  tle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_MAX)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_pos | cmd.rd_j),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next values of the two counts.
  always_comb begin
    line_count_nxt  = line_count_r;
    shown_count_nxt = shown_count_r;
    if (cmd.clr_counts) begin
      line_count_nxt  = 6'd0;
      shown_count_nxt = 6'd0;
    end else if (cmd.store_key) begin
      line_count_nxt  = line_count_r + 6'd1;
      shown_count_nxt = line_count_r + 6'd1;
    end else if (cmd.bs_dec) begin
      line_count_nxt  = line_count_r - 6'd1;
      shown_count_nxt = line_count_r - 6'd1;
    end else if (cmd.line_from_pos) begin
      line_count_nxt  = pos_r;
    end
  end

  // Line state and limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r  <= 6'd40;
      line_count_r  <= 6'd0;
      shown_count_r <= 6'd0;
      finished_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        line_limit_r <= cfg_line_limit;
      end
      line_count_r  <= line_count_nxt;
      shown_count_r <= shown_count_nxt;
      if (cmd.set_fin) begin
        finished_r <= 1'b1;
      end
    end
  end

  // Key, walk position and replay index; payload only.
  always_ff @(posedge clk) begin
    if (cmd.key_ld) begin
      key_r <= in_key_byte;
    end
    if (cmd.pos_init) begin
      pos_r <= line_count_r;
    end else if (cmd.pos_dec) begin
      pos_r <= pos_m1;
    end
    if (cmd.j_clr) begin
      j_r <= 6'd0;
    end else if (cmd.j_inc) begin
      j_r <= j_p1;
    end
  end

  // Byte source for the output register.
  always_comb begin
    case (cmd.byte_sel)
      BSEL_LF:   out_byte = KEY_LF;
      BSEL_NUL:  out_byte = KEY_NUL;
      BSEL_CR:   out_byte = KEY_CR;
      BSEL_BS:   out_byte = KEY_BS;
      BSEL_SP:   out_byte = KEY_SPACE;
      BSEL_BELL: out_byte = KEY_BELL;
      BSEL_KEY:  out_byte = key_r;
      BSEL_RAM:  out_byte = ram_rdata;
      default:   out_byte = KEY_NUL;
    endcase
  end

  // Output register: loaded when free, held until the request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      echo_r <= out_byte;
      last_r <= cmd.out_last;
      end_r  <= cmd.out_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_byte   = echo_r;
  assign out_run_last    = last_r;
  assign out_session_end = end_r;

  assign stat.kclass     = kclass;
  assign stat.finished   = finished_r;
  assign stat.line_zero  = (line_count_r == 6'd0);
  assign stat.room       = (line_count_r < eff_limit);
  assign stat.pos_zero   = (pos_r == 6'd0);
  assign stat.rd_space   = (ram_rdata == KEY_SPACE);
  assign stat.shown_zero = (shown_count_r == 6'd0);
  assign stat.j_last     = (j_p1 == shown_count_r);
  assign stat.out_free   = ~out_valid_r | out_ready;

endmodule

@@ rtl/tle_ctrl.sv @@
module tle_ctrl import tle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tle_stat_t stat,
  output tle_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_ONE  = 4'd2;
  localparam logic [3:0] S_BS1  = 4'd3;
  localparam logic [3:0] S_BS2  = 4'd4;
  localparam logic [3:0] S_BS3  = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_WCHK = 4'd7;
  localparam logic [3:0] S_CR   = 4'd8;
  localparam logic [3:0] S_ERD  = 4'd9;
  localparam logic [3:0] S_ELD  = 4'd10;

  logic [3:0] state_r, state_nxt;
  bsel_t      sel_r, sel_nxt;
  logic       skip_r, skip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= BSEL_BELL;
      skip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      skip_r  <= skip_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Sequencing of one key request.
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    skip_nxt  = skip_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.key_ld = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        if (!stat.finished) begin
          case (stat.kclass)
            KC_CR: begin
              if (!stat.line_zero) begin
                cmd.clr_counts = 1'b1;
                sel_nxt        = BSEL_LF;
                state_nxt      = S_ONE;
              end
            end
            KC_EOT: begin
              if (stat.line_zero) begin
                cmd.set_fin = 1'b1;
                sel_nxt     = BSEL_NUL;
              end else begin
                sel_nxt = BSEL_BELL;
              end
              state_nxt = S_ONE;
            end
            KC_WERASE: begin
              if (!stat.line_zero) begin
                cmd.pos_init = 1'b1;
                skip_nxt     = 1'b1;
                state_nxt    = S_WRD;
              end
            end
            KC_KILL: begin
              cmd.clr_counts = 1'b1;
              sel_nxt        = BSEL_CR;
              state_nxt      = S_ONE;
            end
            KC_BS: begin
              if (!stat.line_zero) begin
                cmd.bs_dec = 1'b1;
                state_nxt  = S_BS1;
              end
            end
            KC_PRINT: begin
              if (stat.room) begin
                cmd.store_key = 1'b1;
                sel_nxt       = BSEL_KEY;
                state_nxt     = S_ONE;
              end
            end
            default: begin
              sel_nxt   = BSEL_BELL;
              state_nxt = S_ONE;
            end
          endcase
        end
      end
      // A run of a single byte.
      S_ONE: begin
        cmd.byte_sel = sel_r;
        cmd.out_last = 1'b1;
        cmd.out_end  = (sel_r == BSEL_NUL);
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      // Backspace, space, backspace.
      S_BS1: begin
        cmd.byte_sel = BSEL_BS;
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_BS2;
        end
      end
      S_BS2: begin
        cmd.byte_sel = BSEL_SP;
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_BS3;
        end
      end
      S_BS3: begin
        cmd.byte_sel = BSEL_BS;
        cmd.out_last = 1'b1;
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      // Word erase walk: read the byte before the position.
      S_WRD: begin
        if (stat.pos_zero) begin
          cmd.line_from_pos = 1'b1;
          state_nxt         = S_CR;
        end else begin
          cmd.rd_pos = 1'b1;
          state_nxt  = S_WCHK;
        end
      end
      // Skip trailing spaces, then blank the word until a space is met.
      S_WCHK: begin
        if (stat.rd_space) begin
          if (skip_r) begin
            cmd.pos_dec = 1'b1;
            state_nxt   = S_WRD;
          end else begin
            cmd.line_from_pos = 1'b1;
            state_nxt         = S_CR;
          end
        end else begin
          skip_nxt     = 1'b0;
          cmd.wr_space = 1'b1;
          cmd.pos_dec  = 1'b1;
          state_nxt    = S_WRD;
        end
      end
      // Carriage return ahead of the redrawn line.
      S_CR: begin
        cmd.byte_sel = BSEL_CR;
        cmd.out_last = stat.shown_zero;
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.j_clr  = 1'b1;
          state_nxt  = stat.shown_zero ? S_IDLE : S_ERD;
        end
      end
      S_ERD: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        cmd.byte_sel = BSEL_RAM;
        cmd.out_last = stat.j_last;
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.j_inc  = 1'b1;
          state_nxt  = stat.j_last ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
